@@ rtl/core/csc_pkg.sv @@
// Shared constants, types and elaboration-time constant builders for the CORDIC sine/cosine core.
package csc_pkg;

  localparam int unsigned ITERATIONS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned GUARD          = 4;
  localparam int unsigned KFRAC          = 27;

  localparam longint unsigned DEC10 = 64'd10000000000;
  localparam longint unsigned DEC18 = 64'd1000000000000000000;

  localparam longint unsigned HALF_PI_DEC  = 64'd1570796326794896619;
  localparam longint unsigned PI_DEC       = 64'd3141592653589793238;
  localparam longint unsigned TH_PI_DEC    = 64'd4712388980384689858;
  localparam longint unsigned TWO_PI_DEC   = 64'd6283185307179586477;
  localparam longint unsigned GAIN_DEC     = 64'd607252935008881256;

  typedef enum logic [1:0] {
    QUAD_1,
    QUAD_2,
    QUAD_3,
    QUAD_4
  } quad_t;

  // round(n / d * 2^bits) for n / d below 8, by restoring long division
  function automatic longint unsigned to_fixed(longint unsigned n, longint unsigned d,
                                               int unsigned bits);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = n;
    for (int k = 0; k < 8; k++) begin
      if (r >= d) begin
        r = r - d;
        q = q + 64'd1;
      end
    end
    for (int unsigned b = 0; b < bits; b++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        q = q | 64'd1;
        r = r - d;
      end
    end
    r = r << 1;
    if (r >= d) begin
      q = q + 64'd1;
    end
    return q;
  endfunction

  function automatic longint unsigned angle_entry(int unsigned i, int unsigned wf);
    longint unsigned v;
    unique case (i)
      0: begin
        v = to_fixed(64'd7853981634, DEC10, wf);
      end
      1: begin
        v = to_fixed(64'd4636476090, DEC10, wf);
      end
      2: begin
        v = to_fixed(64'd2449786631, DEC10, wf);
      end
      3: begin
        v = to_fixed(64'd1243549945, DEC10, wf);
      end
      4: begin
        v = to_fixed(64'd624188100, DEC10, wf);
      end
      default: begin
        v = (64'd1 << wf) >> i;
      end
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/cordic_sine_cosine.sv @@
// Pipelined rotation-mode CORDIC giving cosine and sine of an unsigned angle.
// Throughput: one beat per cycle while the skid stage is empty; one register
// stage per CORDIC iteration, plus range reduction, quadrant split, split gain
// multiply, gain rounding and clip stages.
// A two-entry output register and skid stage decouple in_ready from out_ready.
// Synchronous active-low reset clears valid bits only; no clearing pass.
module cordic_sine_cosine #(
  parameter int unsigned ITERATIONS = csc_pkg::ITERATIONS_DEF,
  parameter int unsigned FRAC_BITS  = csc_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [FRAC_BITS+2:0]        in_angle,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [FRAC_BITS+1:0] out_cos_out,
  output logic signed [FRAC_BITS+1:0] out_sin_out
);

  import csc_pkg::*;

  localparam int unsigned WF = FRAC_BITS + GUARD;
  localparam int unsigned WW = WF + 3;
  localparam int unsigned OW = FRAC_BITS + 2;
  localparam int unsigned LO = WW / 2;
  localparam int unsigned HW = WW - LO;
  localparam int unsigned PW = WW + KFRAC + 1;
  localparam int unsigned PHW = HW + KFRAC + 1;
  localparam int unsigned PLW = LO + KFRAC;

  localparam logic [WW-1:0] HALF_PI_W = WW'(to_fixed(HALF_PI_DEC, DEC18, WF));
  localparam logic [WW-1:0] PI_W      = WW'(to_fixed(PI_DEC, DEC18, WF));
  localparam logic [WW-1:0] TH_PI_W   = WW'(to_fixed(TH_PI_DEC, DEC18, WF));
  localparam logic [WW-1:0] TWO_PI_W  = WW'(to_fixed(TWO_PI_DEC, DEC18, WF));
  localparam logic [KFRAC-1:0] GAIN_K = KFRAC'(to_fixed(GAIN_DEC, DEC18, KFRAC));

  localparam logic signed [WW-1:0] C_INIT = WW'(1) << WF;
  localparam logic signed [PW-1:0] RND_K  = PW'(1) << (KFRAC - 1);
  localparam logic signed [WW-1:0] RND_G  = WW'(1) << (GUARD - 1);
  localparam logic signed [WW-1:0] ONE_W  = WW'(1) << FRAC_BITS;
  localparam logic signed [OW-1:0] ONE_O  = OW'(1) << FRAC_BITS;

  function automatic logic signed [OW-1:0] clip(input logic signed [WW-1:0] v);
    logic signed [OW-1:0] r;
    if (v > ONE_W) begin
      r = ONE_O;
    end else if (v < -ONE_W) begin
      r = -ONE_O;
    end else begin
      r = v[OW-1:0];
    end
    return r;
  endfunction

  logic adv;

  // range reduction
  logic [WW-1:0] a_sh;
  logic [WW-1:0] red_theta;
  logic [WW-1:0] r1_theta_r;
  logic          r1_v_r;

  // quadrant split
  logic [WW-1:0] q_theta;
  quad_t         q_quad;

  // iteration stages
  logic signed [WW-1:0] c_r  [0:ITERATIONS];
  logic signed [WW-1:0] s_r  [0:ITERATIONS];
  logic signed [WW-1:0] x_r  [0:ITERATIONS];
  logic signed [WW-1:0] th_r [0:ITERATIONS];
  quad_t                qd_r [0:ITERATIONS];
  logic                 v_r  [0:ITERATIONS];

  // gain multiply
  logic signed [HW+KFRAC:0] pc_hi_r, ps_hi_r;
  logic [LO+KFRAC-1:0]      pc_lo_r, ps_lo_r;
  quad_t                    m_quad_r;
  logic                     m_v_r;

  // gain rounding
  logic signed [PW-1:0] sum_c, sum_s;
  logic signed [WW-1:0] g_c_r, g_s_r;
  quad_t                g_quad_r;
  logic                 g_v_r;

  // final rounding, quadrant fix-up, clip
  logic signed [WW-1:0] c2, s2, cq, sq;
  logic signed [OW-1:0] fin_c_r, fin_s_r;
  logic                 fin_v_r;

  // output register and skid
  logic                 out_valid_r, out_valid_nxt;
  logic                 skid_v_r, skid_v_nxt;
  logic signed [OW-1:0] out_c_r, out_c_nxt, out_s_r, out_s_nxt;
  logic signed [OW-1:0] skid_c_r, skid_c_nxt, skid_s_r, skid_s_nxt;

  assign adv      = !skid_v_r;
  assign in_ready = adv;

  always_comb begin
    a_sh = {in_angle, {GUARD{1'b0}}};
    if (a_sh >= TWO_PI_W) begin
      red_theta = a_sh - TWO_PI_W;
    end else begin
      red_theta = a_sh;
    end
  end

  always_comb begin
    if (r1_theta_r >= TH_PI_W) begin
      q_quad  = QUAD_4;
      q_theta = r1_theta_r - TH_PI_W;
    end else if (r1_theta_r >= PI_W) begin
      q_quad  = QUAD_3;
      q_theta = r1_theta_r - PI_W;
    end else if (r1_theta_r >= HALF_PI_W) begin
      q_quad  = QUAD_2;
      q_theta = r1_theta_r - HALF_PI_W;
    end else begin
      q_quad  = QUAD_1;
      q_theta = r1_theta_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_theta_r <= red_theta;
      c_r[0]     <= C_INIT;
      s_r[0]     <= '0;
      x_r[0]     <= '0;
      th_r[0]    <= $signed(q_theta);
      qd_r[0]    <= q_quad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_v_r <= 1'b0;
      v_r[0] <= 1'b0;
    end else if (adv) begin
      r1_v_r <= in_valid;
      v_r[0] <= r1_v_r;
    end
  end

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
    localparam logic signed [WW-1:0] ANG = WW'(angle_entry(k, WF));
    logic signed [WW-1:0] cs, ss;
    logic                 up;

    assign cs = c_r[k] >>> k;
    assign ss = s_r[k] >>> k;
    assign up = (x_r[k] <= th_r[k]);

    always_ff @(posedge clk) begin
      if (adv) begin
        if (up) begin
          x_r[k+1] <= x_r[k] + ANG;
          c_r[k+1] <= c_r[k] - ss;
          s_r[k+1] <= s_r[k] + cs;
        end else begin
          x_r[k+1] <= x_r[k] - ANG;
          c_r[k+1] <= c_r[k] + ss;
          s_r[k+1] <= s_r[k] - cs;
        end
        th_r[k+1] <= th_r[k];
        qd_r[k+1] <= qd_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_r[k];
      end
    end
  end

  always_comb begin
    sum_c = (PW'(pc_hi_r) <<< LO) + PW'($signed({1'b0, pc_lo_r})) + RND_K;
    sum_s = (PW'(ps_hi_r) <<< LO) + PW'($signed({1'b0, ps_lo_r})) + RND_K;
  end

  always_comb begin
    c2 = (g_c_r + RND_G) >>> GUARD;
    s2 = (g_s_r + RND_G) >>> GUARD;
    unique case (g_quad_r)
      QUAD_4: begin
        cq = s2;
        sq = -c2;
      end
      QUAD_3: begin
        cq = -c2;
        sq = -s2;
      end
      QUAD_2: begin
        cq = -s2;
        sq = c2;
      end
      default: begin
        cq = c2;
        sq = s2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pc_hi_r  <= PHW'($signed(c_r[ITERATIONS][WW-1:LO])) * PHW'($signed({1'b0, GAIN_K}));
      ps_hi_r  <= PHW'($signed(s_r[ITERATIONS][WW-1:LO])) * PHW'($signed({1'b0, GAIN_K}));
      pc_lo_r  <= PLW'(c_r[ITERATIONS][LO-1:0]) * PLW'(GAIN_K);
      ps_lo_r  <= PLW'(s_r[ITERATIONS][LO-1:0]) * PLW'(GAIN_K);
      m_quad_r <= qd_r[ITERATIONS];
      g_c_r    <= sum_c[KFRAC+WW-1:KFRAC];
      g_s_r    <= sum_s[KFRAC+WW-1:KFRAC];
      g_quad_r <= m_quad_r;
      fin_c_r  <= clip(cq);
      fin_s_r  <= clip(sq);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r   <= 1'b0;
      g_v_r   <= 1'b0;
      fin_v_r <= 1'b0;
    end else if (adv) begin
      m_v_r   <= v_r[ITERATIONS];
      g_v_r   <= m_v_r;
      fin_v_r <= g_v_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    skid_v_nxt    = skid_v_r;
    out_c_nxt     = out_c_r;
    out_s_nxt     = out_s_r;
    skid_c_nxt    = skid_c_r;
    skid_s_nxt    = skid_s_r;
    if (out_valid_r && out_ready) begin
      if (skid_v_r) begin
        out_c_nxt  = skid_c_r;
        out_s_nxt  = skid_s_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (adv && fin_v_r) begin
      if (!out_valid_r || out_ready) begin
        out_c_nxt     = fin_c_r;
        out_s_nxt     = fin_s_r;
        out_valid_nxt = 1'b1;
      end else begin
        skid_c_nxt = fin_c_r;
        skid_s_nxt = fin_s_r;
        skid_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_v_r    <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_c_r  <= out_c_nxt;
    out_s_r  <= out_s_nxt;
    skid_c_r <= skid_c_nxt;
    skid_s_r <= skid_s_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_cos_out = out_c_r;
  assign out_sin_out = out_s_r;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid holds a beat while the output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(skid_v_r) |-> $past(out_valid_r && out_ready))
    else $error("skid emptied without an output beat");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("pending result lost");

  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] |-> (th_r[0] >= 0 && th_r[0] < $signed(HALF_PI_W)))
    else $error("quadrant offset outside [0, pi/2)");

  a_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cos_out <= ONE_O && out_cos_out >= -ONE_O &&
                     out_sin_out <= ONE_O && out_sin_out >= -ONE_O))
    else $error("result outside [-1, 1]");
`endif

endmodule
